FILE: src/static_linked_list_free_list_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the static linked list
// Shorthand for clocked assertions that are disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_FREE_LIST_ASSERT_SVH
`define STATIC_LINKED_LIST_FREE_LIST_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SLL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define SLL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define SLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sll_pkg.sv
// ---------------------------------------------------------------------------
// Static linked list package
// Field widths, operation codes, sequencer states and defaults.
// ---------------------------------------------------------------------------
package sll_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_VALUE_BITS  = 32;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 5;
    localparam int CAP_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int CAPACITY_RESET = 16;

    // Word index of the capacity register.
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_GET    = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_FIX,
        ST_FETCH,
        ST_RESP
    } state_t;

endpackage

FILE: src/sll_req_if.sv
// ---------------------------------------------------------------------------
// Static linked list request channel
// Valid/ready channel carrying one operation request.
// ---------------------------------------------------------------------------
interface sll_req_if
    import sll_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output kind, output pos, output value, input ready);
    modport sink   (input valid, input kind, input pos, input value, output ready);
endinterface

FILE: src/sll_rsp_if.sv
// ---------------------------------------------------------------------------
// Static linked list response channel
// Valid/ready channel carrying one result per request.
// ---------------------------------------------------------------------------
interface sll_rsp_if
    import sll_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [VAL_W-1:0] value_out;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] free_head;

    modport source (output valid, output ok, output value_out, output length,
                    output free_head, input ready);
    modport sink   (input valid, input ok, input value_out, input length,
                    input free_head, output ready);
endinterface

FILE: src/sll_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/static_linked_list_free_list.sv
// ---------------------------------------------------------------------------
// Static linked list with free list
// Array-backed singly linked list: insert, get, delete and clear requests,
// one result per request, with a free list that recycles deleted slots.
// ---------------------------------------------------------------------------
//
//   Channel  Dir  Handshake        Payload
//   -------  ---  ---------------  -------------------------------------
//   req      in   valid / ready    kind, pos, value
//   rsp      out  valid / ready    ok, value_out, length, free_head
//   apb      in   psel / penable   paddr, pwdata, prdata (capacity reg)
//
// A request passes the start step, the link walk to min(pos, length), a fix
// step (insert) or fetch step (get, delete), and the result step; clear or a
// rejected request goes from start to the result step. The walk follows one
// link per cycle through the registered read port of the link RAM.
// Reset leaves the list empty with the free chain 1..capacity; no clearing
// pass is needed, so requests are accepted right after reset.
// A new request is accepted while the previous result still waits in the
// output register; a stalled result only holds the sequencer in its last step.
//
module static_linked_list_free_list
    import sll_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    sll_req_if.sink           req,
    sll_rsp_if.source         rsp
);

`include "static_linked_list_free_list_assert.svh"

    // Slot 0 is the header, slots 1..MAX_ENTRIES hold elements.
    localparam int DEPTH = MAX_ENTRIES + 1;
    localparam int IW    = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = $clog2(MAX_ENTRIES + 2);
    localparam logic [CW-1:0] CAP_RST =
        CW'((MAX_ENTRIES < CAPACITY_RESET) ? MAX_ENTRIES : CAPACITY_RESET);
    localparam logic [IW-1:0] SLOT_FIRST = IW'(1);
    localparam logic [CW-1:0] HWM_FIRST  = CW'(1);

    // Control state.
    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  capacity_reg, capacity_next;
    logic [CW-1:0]     cap_reg, cap_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     free_head_reg, free_head_next;
    logic [CW-1:0]     hwm_reg, hwm_next;
    logic [IW-1:0]     head_link_reg, head_link_next;
    logic              out_valid_reg, out_valid_next;

    // Request payload and walk state.
    kind_t             kind_reg, kind_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [POS_W-1:0]  steps_reg, steps_next;
    logic [IW-1:0]     newhead_reg, newhead_next;
    logic [IW-1:0]     obj_reg, obj_next;
    logic              ok_reg, ok_next;
    logic [VALUE_BITS-1:0] vout_reg, vout_next;

    // Output register payload.
    logic              out_ok_reg, out_ok_next;
    logic [VAL_W-1:0]  out_vout_reg, out_vout_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [LEN_W-1:0]  out_fh_reg, out_fh_next;

    // RAM ports.
    logic                  v_we;
    logic [IW-1:0]         v_waddr, v_raddr;
    logic [VALUE_BITS-1:0] v_wdata, v_rdata;
    logic                  l_we;
    logic [IW-1:0]         l_waddr, l_raddr, l_wdata, l_rdata;
    logic                  f_we;
    logic [IW-1:0]         f_waddr, f_raddr, f_wdata, f_rdata;

    logic [IW-1:0]     nx;
    logic [IW-1:0]     virt_next;
    logic              fresh;
    logic [CW-1:0]     cap_clamped;
    logic              cfg_write;

    sll_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_value_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    sll_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    sll_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // Configuration port. The capacity value only takes effect at reset and
    // at a clear request.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity_reg) : '0;

    assign capacity_next = cfg_write ? pwdata[CAP_W-1:0] : capacity_reg;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_clamped = CW'(1);
        end
        else if (32'(capacity_reg) > MAX_ENTRIES)
        begin
            cap_clamped = CW'(MAX_ENTRIES);
        end
        else
        begin
            cap_clamped = CW'(capacity_reg);
        end
    end

    // Link out of the current walk position: the header link lives in a
    // register, all other links come from the read issued in the last cycle.
    assign nx = (cur_reg == '0) ? head_link_reg : l_rdata;

    // The free chain is kept lazily. Slots at or above the high-water mark
    // have never been handed out since the last rebuild, so their free link
    // is the initial chain value; slots below it were freed by a delete,
    // which wrote their free link into the RAM.
    assign fresh     = (32'(free_head_reg) >= 32'(hwm_reg));
    assign virt_next = (32'(free_head_reg) < 32'(cap_reg)) ? IW'(free_head_reg + 1'b1) : '0;

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.ok        = out_ok_reg;
    assign rsp.value_out = out_vout_reg;
    assign rsp.length    = out_len_reg;
    assign rsp.free_head = out_fh_reg;

    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        count_next     = count_reg;
        free_head_next = free_head_reg;
        hwm_next       = hwm_reg;
        head_link_next = head_link_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        newhead_next   = newhead_reg;
        obj_next       = obj_reg;
        ok_next        = ok_reg;
        vout_next      = vout_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_vout_next  = out_vout_reg;
        out_len_next   = out_len_reg;
        out_fh_next    = out_fh_reg;

        v_we    = 1'b0;
        v_waddr = '0;
        v_wdata = val_reg;
        v_raddr = '0;
        l_we    = 1'b0;
        l_waddr = '0;
        l_wdata = '0;
        l_raddr = '0;
        f_we    = 1'b0;
        f_waddr = '0;
        f_wdata = free_head_reg;
        // The free link of the head slot is always being fetched, so it is
        // ready in the cycle after an insert is accepted.
        f_raddr = free_head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = kind_t'(req.kind);
                    pos_next   = req.pos;
                    val_next   = VALUE_BITS'(req.value);
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                ok_next    = 1'b0;
                vout_next  = '0;
                cur_next   = '0;
                steps_next = '0;
                unique case (kind_reg) inside
                    KIND_CLEAR:
                    begin
                        cap_next       = cap_clamped;
                        count_next     = '0;
                        head_link_next = '0;
                        free_head_next = SLOT_FIRST;
                        hwm_next       = HWM_FIRST;
                        ok_next        = 1'b1;
                        state_next     = ST_RESP;
                    end
                    KIND_INSERT:
                    begin
                        if ((32'(count_reg) >= 32'(cap_reg)) || (free_head_reg == '0))
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            newhead_next = fresh ? virt_next : f_rdata;
                            v_we         = 1'b1;
                            v_waddr      = free_head_reg;
                            state_next   = ST_WALK;
                        end
                    end
                    KIND_GET, KIND_DELETE:
                    begin
                        if (32'(pos_reg) >= 32'(count_reg))
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_WALK:
            begin
                if ((steps_reg == pos_reg) || (nx == '0))
                begin
                    if (kind_reg == KIND_INSERT)
                    begin
                        // New slot points where the current slot pointed.
                        l_we       = 1'b1;
                        l_waddr    = free_head_reg;
                        l_wdata    = nx;
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        // Fetch the element and its onward link.
                        obj_next   = nx;
                        l_raddr    = nx;
                        v_raddr    = nx;
                        state_next = ST_FETCH;
                    end
                end
                else
                begin
                    cur_next   = nx;
                    steps_next = steps_reg + 1'b1;
                    l_raddr    = nx;
                end
            end

            ST_FIX:
            begin
                if (cur_reg == '0)
                begin
                    head_link_next = free_head_reg;
                end
                else
                begin
                    l_we    = 1'b1;
                    l_waddr = cur_reg;
                    l_wdata = free_head_reg;
                end
                if (fresh)
                begin
                    hwm_next = CW'(32'(free_head_reg) + 1);
                end
                free_head_next = newhead_reg;
                count_next     = count_reg + 1'b1;
                ok_next        = 1'b1;
                state_next     = ST_RESP;
            end

            ST_FETCH:
            begin
                vout_next = v_rdata;
                ok_next   = 1'b1;
                if (kind_reg == KIND_DELETE)
                begin
                    if (cur_reg == '0)
                    begin
                        head_link_next = l_rdata;
                    end
                    else
                    begin
                        l_we    = 1'b1;
                        l_waddr = cur_reg;
                        l_wdata = l_rdata;
                    end
                    // Freed slot goes to the front of the free chain.
                    f_we           = 1'b1;
                    f_waddr        = obj_reg;
                    free_head_next = obj_reg;
                    count_next     = count_reg - 1'b1;
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_vout_next  = VAL_W'(vout_reg);
                    out_len_next   = LEN_W'(32'(count_reg));
                    out_fh_next    = LEN_W'(32'(free_head_reg));
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_W'(CAPACITY_RESET);
            cap_reg       <= CAP_RST;
            count_reg     <= '0;
            free_head_reg <= SLOT_FIRST;
            hwm_reg       <= HWM_FIRST;
            head_link_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            free_head_reg <= free_head_next;
            hwm_reg       <= hwm_next;
            head_link_reg <= head_link_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
        newhead_reg  <= newhead_next;
        obj_reg      <= obj_next;
        ok_reg       <= ok_next;
        vout_reg     <= vout_next;
        out_ok_reg   <= out_ok_next;
        out_vout_reg <= out_vout_next;
        out_len_reg  <= out_len_next;
        out_fh_reg   <= out_fh_next;
    end

    // The element count never exceeds the capacity.
    `SLL_ASSERT_ALWAYS(a_count_le_cap, count_reg <= cap_reg, "count exceeds capacity")
    // The free chain is empty only when every slot holds an element.
    `SLL_ASSERT_IMPL(a_free_empty_full, free_head_reg == '0, count_reg == cap_reg,
                     "free chain empty while slots remain")
    // The high-water mark stays within one past the last slot.
    `SLL_ASSERT_ALWAYS(a_hwm_range, 32'(hwm_reg) <= 32'(cap_reg) + 1,
                       "high-water mark out of range")
    // An accepted request starts the sequencer in the next cycle.
    `SLL_ASSERT_NEXT(a_accept_start, req.valid && req.ready, state_reg == ST_START,
                     "accepted request did not start")
    // A result appears in the output register only from the result step.
    `SLL_ASSERT_IMPL(a_result_from_resp, $rose(out_valid_reg), $past(state_reg == ST_RESP),
                     "result loaded outside the result step")

endmodule
